/* hw/rtl/pfb_pkg.sv */
`default_nettype none

package pfb_pkg;

    localparam int REQ_W = 2;
    localparam int POS_X_W = 9;
    localparam int POS_Y_W = 8;
    localparam int RECT_W_W = 9;
    localparam int RECT_H_W = 8;
    localparam int INDEX_W = 8;
    localparam int COLOR_W = 16;
    localparam int BAND_W = 8;

    localparam int IN_DATA_W = 64;
    localparam int POS_X_LSB = 0;
    localparam int POS_Y_LSB = POS_X_LSB + POS_X_W;
    localparam int RECT_W_LSB = POS_Y_LSB + POS_Y_W;
    localparam int RECT_H_LSB = RECT_W_LSB + RECT_W_W;
    localparam int INDEX_LSB = RECT_H_LSB + RECT_H_W;
    localparam int COLOR_LSB = INDEX_LSB + INDEX_W;

    // Wide enough for a fill corner plus its size and for a screen side of up to 1024.
    localparam int CLIP_W = 11;

    localparam logic [REQ_W-1:0] REQ_PALETTE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FILL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SCAN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL_SETUP,
        ST_FILL,
        ST_SCAN_PAL,
        ST_SCAN_OUT
    } pfb_state_t;

    typedef struct packed {
        logic accept_pal;
        logic accept_fill;
        logic accept_scan;
        logic fill_setup;
        logic fill_step;
        logic scan_pal;
        logic out_load;
    } pfb_cmd_t;

    typedef struct packed {
        logic fill_empty;
        logic fill_last;
        logic out_free;
    } pfb_status_t;

endpackage

`default_nettype wire

/* hw/rtl/pfb_ctrl.sv */
`default_nettype none

module pfb_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    input  wire logic [pfb_pkg::REQ_W-1:0]   s_axis_tuser,
    output logic                             s_axis_tready,
    output pfb_pkg::pfb_cmd_t                cmd,
    input  wire pfb_pkg::pfb_status_t        status
);

    pfb_pkg::pfb_state_t state_reg;
    pfb_pkg::pfb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            pfb_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    unique case (s_axis_tuser)
                        pfb_pkg::REQ_PALETTE:
                        begin
                            cmd.accept_pal = 1'b1;
                        end
                        pfb_pkg::REQ_FILL:
                        begin
                            cmd.accept_fill = 1'b1;
                            state_next = pfb_pkg::ST_FILL_SETUP;
                        end
                        pfb_pkg::REQ_SCAN:
                        begin
                            cmd.accept_scan = 1'b1;
                            state_next = pfb_pkg::ST_SCAN_PAL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pfb_pkg::ST_FILL_SETUP:
            begin
                cmd.fill_setup = 1'b1;
                state_next = status.fill_empty ? pfb_pkg::ST_IDLE : pfb_pkg::ST_FILL;
            end
            pfb_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_last)
                begin
                    state_next = pfb_pkg::ST_IDLE;
                end
            end
            pfb_pkg::ST_SCAN_PAL:
            begin
                cmd.scan_pal = 1'b1;
                state_next = pfb_pkg::ST_SCAN_OUT;
            end
            pfb_pkg::ST_SCAN_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = pfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/pfb_datapath.sv */
`default_nettype none

module pfb_datapath #(
    parameter int SCREEN_WIDTH = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pfb_pkg::pfb_cmd_t                 cmd,
    output pfb_pkg::pfb_status_t                   status,
    input  wire logic [pfb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                              band_rows_wr_en,
    input  wire logic [pfb_pkg::BAND_W-1:0]        band_rows_wr_data,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [pfb_pkg::COLOR_W-1:0]            m_axis_tdata,
    output logic [0:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast
);

    localparam int TOTAL = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int XW = $clog2(SCREEN_WIDTH + 1);
    localparam int PW = $clog2(PALETTE_ENTRIES);
    localparam int CW = pfb_pkg::CLIP_W;
    localparam int IW = pfb_pkg::INDEX_W;
    localparam int BW = pfb_pkg::BAND_W;

    logic [IW-1:0] frame_mem [TOTAL];
    logic [pfb_pkg::COLOR_W-1:0] pal_mem [PALETTE_ENTRIES];

    logic [pfb_pkg::POS_X_W-1:0] in_x;
    logic [pfb_pkg::POS_Y_W-1:0] in_y;
    logic [pfb_pkg::RECT_W_W-1:0] in_w;
    logic [pfb_pkg::RECT_H_W-1:0] in_h;
    logic [IW-1:0] in_index;
    logic [pfb_pkg::COLOR_W-1:0] in_color;

    logic [CW-1:0] x_end;
    logic [CW-1:0] y_end;

    logic [CW-1:0] fill_x0_reg;
    logic [CW-1:0] fill_y0_reg;
    logic [CW-1:0] fill_x1_reg;
    logic [CW-1:0] fill_y1_reg;
    logic [IW-1:0] fill_index_reg;
    logic [CW-1:0] fill_col_reg;
    logic [CW-1:0] fill_row_reg;
    logic [AW-1:0] fill_addr_reg;
    logic [AW-1:0] row_start_reg;
    logic [AW-1:0] start_addr;
    logic [AW-1:0] next_row_addr;
    logic col_last;

    logic [AW-1:0] scan_pos_reg;
    logic [AW-1:0] scan_pos_next;
    logic [XW-1:0] scan_col_reg;
    logic [XW-1:0] scan_col_next;
    logic [BW-1:0] band_cnt_reg;
    logic [BW-1:0] band_cnt_next;
    logic [BW-1:0] band_rows_reg;
    logic [BW-1:0] band_limit;
    logic [BW-1:0] band_cnt_inc;
    logic scan_row_end;
    logic scan_frame_end;
    logic band_end_now;

    logic band_end_reg;
    logic frame_end_reg;
    logic [IW-1:0] frame_rd_reg;
    logic [pfb_pkg::COLOR_W-1:0] pal_rd_reg;
    logic pal_oob_reg;

    logic m_valid_reg;
    logic [pfb_pkg::COLOR_W-1:0] m_data_reg;
    logic m_band_reg;
    logic m_last_reg;

    assign in_x = s_axis_tdata[pfb_pkg::POS_X_LSB +: pfb_pkg::POS_X_W];
    assign in_y = s_axis_tdata[pfb_pkg::POS_Y_LSB +: pfb_pkg::POS_Y_W];
    assign in_w = s_axis_tdata[pfb_pkg::RECT_W_LSB +: pfb_pkg::RECT_W_W];
    assign in_h = s_axis_tdata[pfb_pkg::RECT_H_LSB +: pfb_pkg::RECT_H_W];
    assign in_index = s_axis_tdata[pfb_pkg::INDEX_LSB +: IW];
    assign in_color = s_axis_tdata[pfb_pkg::COLOR_LSB +: pfb_pkg::COLOR_W];

    // The far edge of the fill is clipped to the screen before it is stored.
    always_comb
    begin
        x_end = CW'(in_x) + CW'(in_w);
        y_end = CW'(in_y) + CW'(in_h);
        if (x_end > CW'(SCREEN_WIDTH))
        begin
            x_end = CW'(SCREEN_WIDTH);
        end
        if (y_end > CW'(SCREEN_HEIGHT))
        begin
            y_end = CW'(SCREEN_HEIGHT);
        end
    end

    assign start_addr = AW'(fill_y0_reg) * AW'(SCREEN_WIDTH) + AW'(fill_x0_reg);
    assign next_row_addr = row_start_reg + AW'(SCREEN_WIDTH);
    assign col_last = (fill_col_reg == fill_x1_reg - CW'(1));

    assign status.fill_empty = (fill_x0_reg >= fill_x1_reg) || (fill_y0_reg >= fill_y1_reg);
    assign status.fill_last = col_last && (fill_row_reg == fill_y1_reg - CW'(1));
    assign status.out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.accept_fill)
        begin
            fill_x0_reg <= CW'(in_x);
            fill_y0_reg <= CW'(in_y);
            fill_x1_reg <= x_end;
            fill_y1_reg <= y_end;
            fill_index_reg <= in_index;
        end
        if (cmd.fill_setup)
        begin
            fill_col_reg <= fill_x0_reg;
            fill_row_reg <= fill_y0_reg;
            fill_addr_reg <= start_addr;
            row_start_reg <= start_addr;
        end
        else if (cmd.fill_step)
        begin
            if (col_last)
            begin
                fill_col_reg <= fill_x0_reg;
                fill_row_reg <= fill_row_reg + CW'(1);
                fill_addr_reg <= next_row_addr;
                row_start_reg <= next_row_addr;
            end
            else
            begin
                fill_col_reg <= fill_col_reg + CW'(1);
                fill_addr_reg <= fill_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_step)
        begin
            frame_mem[fill_addr_reg] <= fill_index_reg;
        end
        if (cmd.accept_scan)
        begin
            frame_rd_reg <= frame_mem[scan_pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_pal && ({1'b0, in_index} < (IW + 1)'(PALETTE_ENTRIES)))
        begin
            pal_mem[in_index[PW-1:0]] <= in_color;
        end
        if (cmd.scan_pal)
        begin
            pal_rd_reg <= pal_mem[frame_rd_reg[PW-1:0]];
            pal_oob_reg <= ({1'b0, frame_rd_reg} >= (IW + 1)'(PALETTE_ENTRIES));
        end
    end

    // A band of zero rows is treated as one row, and the last pixel of the frame
    // always closes its band.
    always_comb
    begin
        band_limit = (band_rows_reg == '0) ? BW'(1) : band_rows_reg;
        band_cnt_inc = band_cnt_reg + BW'(1);
        scan_row_end = (scan_col_reg == XW'(SCREEN_WIDTH - 1));
        scan_frame_end = (scan_pos_reg == AW'(TOTAL - 1));
        band_end_now = 1'b0;
        band_cnt_next = band_cnt_reg;
        if (scan_row_end)
        begin
            if (band_cnt_inc >= band_limit)
            begin
                band_end_now = 1'b1;
                band_cnt_next = '0;
            end
            else
            begin
                band_cnt_next = band_cnt_inc;
            end
        end
        if (scan_frame_end)
        begin
            band_end_now = 1'b1;
            band_cnt_next = '0;
            scan_pos_next = '0;
            scan_col_next = '0;
        end
        else
        begin
            scan_pos_next = scan_pos_reg + AW'(1);
            scan_col_next = scan_row_end ? '0 : scan_col_reg + XW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg <= '0;
            scan_col_reg <= '0;
            band_cnt_reg <= '0;
            band_rows_reg <= BW'(1);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept_scan)
            begin
                scan_pos_reg <= scan_pos_next;
                scan_col_reg <= scan_col_next;
                band_cnt_reg <= band_cnt_next;
            end
            if (band_rows_wr_en)
            begin
                band_rows_reg <= band_rows_wr_data;
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_scan)
        begin
            band_end_reg <= band_end_now;
            frame_end_reg <= scan_frame_end;
        end
        if (cmd.out_load)
        begin
            m_data_reg <= pal_oob_reg ? '0 : pal_rd_reg;
            m_band_reg <= band_end_reg;
            m_last_reg <= frame_end_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;
    assign m_axis_tuser = m_band_reg;
    assign m_axis_tlast = m_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/palette_framebuffer_fill_scanout.sv */
`default_nettype none

// An 8-bit palette-indexed frame store with a 16-bit colour palette. Each request
// on the slave stream is a palette write, a rectangle fill or a scan of the next
// pixel in row-major order; only a scan returns an item on the master stream,
// with band_end in tuser and frame_end on tlast. A palette write is done as it is
// taken. A fill steps the single frame store write port across the clipped
// rectangle, one on-screen pixel at a time, after a setup step. A scan reads the
// frame store, then the palette, then loads the output register once it is free;
// that register may hold a finished pixel while the next request is taken.
// Neither store is cleared after reset, so each must be written before it is read.
module palette_framebuffer_fill_scanout #(
    parameter int SCREEN_WIDTH = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pos_x, pos_y, rect_width, rect_height, color_index, palette_value, zero fill
    input  wire logic [pfb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // req_type
    input  wire logic [pfb_pkg::REQ_W-1:0]         s_axis_tuser,
    input  wire logic                              band_rows_wr_en,
    input  wire logic [pfb_pkg::BAND_W-1:0]        band_rows_wr_data,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // pixel_color
    output logic [pfb_pkg::COLOR_W-1:0]            m_axis_tdata,
    // band_end
    output logic [0:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast
);

    pfb_pkg::pfb_cmd_t cmd;
    pfb_pkg::pfb_status_t status;

    pfb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .status        (status)
    );

    pfb_datapath #(
        .SCREEN_WIDTH    (SCREEN_WIDTH),
        .SCREEN_HEIGHT   (SCREEN_HEIGHT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .s_axis_tdata      (s_axis_tdata),
        .band_rows_wr_en   (band_rows_wr_en),
        .band_rows_wr_data (band_rows_wr_data),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tuser      (m_axis_tuser),
        .m_axis_tlast      (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* hw/rtl/pfb_checker.sv */
`default_nettype none

module pfb_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [pfb_pkg::REQ_W-1:0]         s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [pfb_pkg::COLOR_W-1:0]       m_axis_tdata,
    input wire logic [0:0]                        m_axis_tuser,
    input wire logic                              m_axis_tlast
);

    logic scan_accept;

    assign scan_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == pfb_pkg::REQ_SCAN);

    // A stalled pixel stays on the bus unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled pixel changed or vanished");

    // The scan pipeline holds off further requests while it reads both stores.
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        scan_accept |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("request taken while a scan was in progress");

    // A pixel appears on an idle bus after its scan request has passed the palette read and the output load states.
    a_scan_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(scan_accept, 3))
        else $error("pixel appeared without a matching scan request");

    // The last pixel of a frame also closes its band.
    a_frame_band: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("frame end without band end");

endmodule

bind palette_framebuffer_fill_scanout pfb_checker u_pfb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
